@@ rtl/core/stereo_feedback_delay_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo feedback delay core
// Assertions compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_CORE_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define SFD_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("sfd assertion failed");

`define SFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfd assertion failed");

`else

`define SFD_ASSERT(lbl, clk, rstn, expr)

`define SFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/core/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, register codes, limits and the microprogram of the feedback delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int unsigned STEP_W    = 4;
  localparam int unsigned NUM_STEPS = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned LINE_W    = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAMES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_COEF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG     = 3'd5;

  // Reset values.
  localparam logic [15:0] RST_DELAY_FRAMES  = 16'd18000;
  localparam logic [14:0] RST_FEEDBACK_GAIN = 15'd11469;
  localparam logic [15:0] RST_DAMP_COEF     = 16'd25805;
  localparam logic [15:0] RST_WET_GAIN      = 16'd0;
  localparam logic [15:0] RST_DRY_GAIN      = 16'd32768;
  localparam logic        RST_PING_PONG     = 1'b0;

  // Limits applied to register values at use.
  localparam logic [14:0] FEEDBACK_MAX = 15'd31129;
  localparam logic [15:0] DAMP_MIN     = 16'd4915;
  localparam logic [15:0] UNITY_GAIN   = 16'd32768;

  typedef enum logic [3:0] {
    OP_RD,      // read both lines at the tap position
    OP_TAP,     // capture the tap, zero for a never-written entry
    OP_DAMP,    // product = damp * (tap - lowpass)
    OP_LPUPD,   // lowpass += product / 2^15
    OP_FBMUL,   // product = feedback * selected lowpass
    OP_WR,      // line[write_pos] = dry * 1024 + product / 2^15
    OP_MDRY,    // product = dry * dry_gain
    OP_ACCLD,   // acc = product * 1024
    OP_MWET,    // product = tap * wet_gain
    OP_ACCADD,  // acc += product
    OP_RES,     // result = sat16(acc / 2^25)
    OP_ADV,     // advance the write position
    OP_EMIT     // hand the frame to the output register
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic en;
    op_e  op;
    logic ch;
  } dp_ctrl_t;

  typedef struct packed {
    logic [15:0] delay_frames;
    logic [14:0] feedback_gain;
    logic [15:0] damp_coef;
    logic [15:0] wet_gain;
    logic [15:0] dry_gain;
    logic        ping_pong;
  } cfg_t;

  localparam logic [STEP_W-1:0] STEP_START = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DAMP  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FB    = 4'd4;

  // A jumping step loops once: it jumps while working on the left channel and
  // falls through on the right one.
  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{OP_RD,     1'b0, STEP_START},
    '{OP_TAP,    1'b0, STEP_START},
    '{OP_DAMP,   1'b0, STEP_START},
    '{OP_LPUPD,  1'b1, STEP_DAMP},
    '{OP_FBMUL,  1'b0, STEP_START},
    '{OP_WR,     1'b0, STEP_START},
    '{OP_MDRY,   1'b0, STEP_START},
    '{OP_ACCLD,  1'b0, STEP_START},
    '{OP_MWET,   1'b0, STEP_START},
    '{OP_ACCADD, 1'b0, STEP_START},
    '{OP_RES,    1'b1, STEP_FB},
    '{OP_ADV,    1'b0, STEP_START},
    '{OP_EMIT,   1'b0, STEP_START}
  };

endpackage

`default_nettype wire

@@ rtl/core/sfd_stream_if.sv @@
// ----------------------------------------------------------------------------
// sfd_stream_if
// Valid/ready channels for input frames and mixed output frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfd_line_ram.sv @@
// ----------------------------------------------------------------------------
// sfd_line_ram
// Single-port delay line memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_line_ram #(
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [sfd_pkg::LINE_W-1:0]  wdata_i,
  output logic [sfd_pkg::LINE_W-1:0]  rdata_o
);

  logic [sfd_pkg::LINE_W-1:0] mem_q [DEPTH];
  logic [sfd_pkg::LINE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/sfd_sequencer.sv @@
// ----------------------------------------------------------------------------
// sfd_sequencer
// Step counter over the microprogram, loop control and frame handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_feedback_delay_core_assert.svh"

module sfd_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfd_pkg::dp_ctrl_t ctrl_o
);

  logic                       busy_q, busy_d;
  logic [sfd_pkg::STEP_W-1:0] step_q, step_d;
  logic                       ch_q, ch_d;
  logic                       out_valid_q, out_valid_d;
  sfd_pkg::ucode_t            word;
  logic                       accept;
  logic                       stall;
  logic                       fire;
  logic                       emit;

  assign word   = sfd_pkg::UCODE[step_q];
  assign accept = in_valid_i && !busy_q;
  // The last step waits while the output register still holds a frame that the sink has not taken.
  assign stall  = (word.op == sfd_pkg::OP_EMIT) && out_valid_q && !out_ready_i;
  assign fire   = busy_q && !stall;
  assign emit   = fire && (word.op == sfd_pkg::OP_EMIT);

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    ch_d        = ch_q;
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    if (accept) begin
      busy_d = 1'b1;
      step_d = sfd_pkg::STEP_START;
      ch_d   = 1'b0;
    end else if (fire) begin
      if (emit) begin
        busy_d = 1'b0;
        step_d = sfd_pkg::STEP_START;
      end else if (word.jump) begin
        ch_d   = !ch_q;
        step_d = ch_q ? step_q + sfd_pkg::STEP_W'(1) : word.target;
      end else begin
        step_d = step_q + sfd_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= sfd_pkg::STEP_START;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign ctrl_o      = '{accept: accept, en: fire, op: word.op, ch: ch_q};

  `SFD_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept,
                   busy_q && (step_q == sfd_pkg::STEP_START) && !ch_q)
  `SFD_ASSERT(a_emit_slot_free, clk_i, rst_ni, !emit || !out_valid_q || out_ready_i)
  `SFD_ASSERT(a_ch_outside_loops, clk_i, rst_ni,
              !(busy_q && (word.op == sfd_pkg::OP_RD || word.op == sfd_pkg::OP_TAP ||
                word.op == sfd_pkg::OP_ADV || word.op == sfd_pkg::OP_EMIT)) || !ch_q)
  `SFD_ASSERT_NEXT(a_emit_shows_frame, clk_i, rst_ni, emit, out_valid_q && !busy_q)

endmodule

`default_nettype wire

@@ rtl/core/sfd_datapath.sv @@
// ----------------------------------------------------------------------------
// sfd_datapath
// Delay lines, lowpass state, one shared multiplier and the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_feedback_delay_core_assert.svh"

module sfd_datapath #(
  parameter int unsigned LINE_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfd_pkg::dp_ctrl_t  ctrl_i,
  input  sfd_pkg::cfg_t      cfg_i,
  input  logic signed [15:0] left_in_i,
  input  logic signed [15:0] right_in_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o
);

  localparam int unsigned AW   = $clog2(LINE_DEPTH);
  localparam int unsigned PW   = (AW > 16) ? AW + 1 : 17;
  localparam int unsigned DMAX = LINE_DEPTH - 1;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
    if (v > 27'sd32767) begin
      return 16'sh7fff;
    end else if (v < -27'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // Control state.
  logic [AW-1:0] wpos_q;
  logic          wrapped_q;

  // Payload registers.
  logic signed [15:0] dry_l_q, dry_r_q;
  logic signed [31:0] tap_l_q, tap_r_q;
  logic signed [31:0] lp_l_q, lp_r_q;
  logic signed [50:0] prod_q;
  logic signed [51:0] acc_q;
  logic signed [15:0] res_l_q, res_r_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic               tap_vld_q;

  logic [PW-1:0]      d_raw, d_use, w_ext, rpos_ext;
  logic [AW-1:0]      rpos;
  logic [AW-1:0]      ram_addr;
  logic               ram_en, we_l, we_r;
  logic [31:0]        rdata_l, rdata_r;
  logic signed [15:0] dry_sel;
  logic signed [31:0] tap_cur, lp_cur, lp_oth, lp_sel;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [50:0] q15_sum;
  logic signed [35:0] q15;
  logic signed [31:0] lp_new;
  logic signed [31:0] line_wdata;
  logic signed [51:0] q25_sum;
  logic signed [15:0] res_new;
  logic               is_rd, is_wr;

  // Tap position, delay held to 1 .. LINE_DEPTH-1.
  always_comb begin
    d_raw = PW'(cfg_i.delay_frames);
    if (d_raw == '0) begin
      d_use = PW'(1);
    end else if (d_raw > PW'(DMAX)) begin
      d_use = PW'(DMAX);
    end else begin
      d_use = d_raw;
    end
    w_ext = PW'(wpos_q);
    if (w_ext >= d_use) begin
      rpos_ext = w_ext - d_use;
    end else begin
      rpos_ext = w_ext + PW'(LINE_DEPTH) - d_use;
    end
    rpos = rpos_ext[AW-1:0];
  end

  assign is_rd    = ctrl_i.en && (ctrl_i.op == sfd_pkg::OP_RD);
  assign is_wr    = ctrl_i.en && (ctrl_i.op == sfd_pkg::OP_WR);
  assign ram_en   = is_rd || is_wr;
  assign ram_addr = is_wr ? wpos_q : rpos;
  assign we_l     = is_wr && !ctrl_i.ch;
  assign we_r     = is_wr && ctrl_i.ch;

  assign dry_sel = ctrl_i.ch ? dry_r_q : dry_l_q;
  assign tap_cur = ctrl_i.ch ? tap_r_q : tap_l_q;
  assign lp_cur  = ctrl_i.ch ? lp_r_q : lp_l_q;
  assign lp_oth  = ctrl_i.ch ? lp_l_q : lp_r_q;
  assign lp_sel  = cfg_i.ping_pong ? lp_oth : lp_cur;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.op)
      sfd_pkg::OP_DAMP: begin
        mul_a = 33'(tap_cur) - 33'(lp_cur);
        mul_b = 18'(cfg_i.damp_coef);
      end
      sfd_pkg::OP_FBMUL: begin
        mul_a = 33'(lp_sel);
        mul_b = 18'(cfg_i.feedback_gain);
      end
      sfd_pkg::OP_MDRY: begin
        mul_a = 33'(dry_sel);
        mul_b = 18'(cfg_i.dry_gain);
      end
      sfd_pkg::OP_MWET: begin
        mul_a = 33'(tap_cur);
        mul_b = 18'(cfg_i.wet_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Division by 2^15 and 2^25 truncates toward zero: negative values get a
  // bias of the divisor minus one before the shift.
  assign q15_sum    = prod_q + (prod_q[50] ? 51'sd32767 : 51'sd0);
  assign q15        = q15_sum[50:15];
  assign lp_new     = sat32(40'(lp_cur) + 40'(q15));
  assign line_wdata = sat32((40'(dry_sel) <<< 10) + 40'(q15));
  assign q25_sum    = acc_q + (acc_q[51] ? 52'sd33554431 : 52'sd0);
  assign res_new    = sat16(q25_sum[51:25]);

  sfd_line_ram #(
    .DEPTH(LINE_DEPTH)
  ) u_left_line (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (we_l),
    .addr_i  (ram_addr),
    .wdata_i (line_wdata),
    .rdata_o (rdata_l)
  );

  sfd_line_ram #(
    .DEPTH(LINE_DEPTH)
  ) u_right_line (
    .clk_i   (clk_i),
    .en_i    (ram_en && !we_l),
    .we_i    (we_r),
    .addr_i  (ram_addr),
    .wdata_i (line_wdata),
    .rdata_o (rdata_r)
  );

  // Entries are written in address order from reset, so until the first wrap
  // only addresses below the write position hold data; others read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      wrapped_q <= 1'b0;
    end else if (ctrl_i.en && (ctrl_i.op == sfd_pkg::OP_ADV)) begin
      if (wpos_q == AW'(DMAX)) begin
        wpos_q    <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wpos_q <= wpos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      dry_l_q <= left_in_i;
      dry_r_q <= right_in_i;
    end
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        sfd_pkg::OP_RD: begin
          tap_vld_q <= wrapped_q || (rpos < wpos_q);
        end
        sfd_pkg::OP_TAP: begin
          tap_l_q <= tap_vld_q ? rdata_l : '0;
          tap_r_q <= tap_vld_q ? rdata_r : '0;
        end
        sfd_pkg::OP_DAMP, sfd_pkg::OP_FBMUL, sfd_pkg::OP_MDRY: begin
          prod_q <= mul_p;
        end
        sfd_pkg::OP_ACCLD: begin
          acc_q <= {prod_q[41:0], 10'b0};
        end
        sfd_pkg::OP_MWET: begin
          prod_q <= mul_p;
        end
        sfd_pkg::OP_ACCADD: begin
          acc_q <= acc_q + 52'(prod_q);
        end
        sfd_pkg::OP_RES: begin
          if (ctrl_i.ch) begin
            res_r_q <= res_new;
          end else begin
            res_l_q <= res_new;
          end
        end
        sfd_pkg::OP_EMIT: begin
          out_l_q <= res_l_q;
          out_r_q <= res_r_q;
        end
        default: begin
        end
      endcase
    end
  end

  // The lowpass state is cleared at reset; the lines are not, and read as zero until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_l_q <= '0;
      lp_r_q <= '0;
    end else if (ctrl_i.en && (ctrl_i.op == sfd_pkg::OP_LPUPD)) begin
      if (ctrl_i.ch) begin
        lp_r_q <= lp_new;
      end else begin
        lp_l_q <= lp_new;
      end
    end
  end

  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  `SFD_ASSERT(a_wpos_range, clk_i, rst_ni, wpos_q <= AW'(DMAX))
  `SFD_ASSERT(a_wrap_sticky, clk_i, rst_ni, !$fell(wrapped_q))
  `SFD_ASSERT(a_tap_not_wpos, clk_i, rst_ni, !is_rd || (rpos != wpos_q))

endmodule

`default_nettype wire

@@ rtl/core/stereo_feedback_delay_core.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core: stereo ping-pong feedback delay with damping
// A new input frame is taken only once the previous frame has been handed to
// the output register; the microprogram runs both channels through one shared
// 33x18 multiplier and the single port of each line RAM.
// Reset: registers to defaults, lines read as silence until written (no pass).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_delay_core #(
  parameter int unsigned LINE_DEPTH = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfd_in_if.sink                          in_i,
  sfd_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfd_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  logic [15:0]       delay_frames_q;
  logic [14:0]       feedback_gain_q;
  logic [15:0]       damp_coef_q;
  logic [15:0]       wet_gain_q;
  logic [15:0]       dry_gain_q;
  logic              ping_pong_q;
  sfd_pkg::cfg_t     cfg;
  sfd_pkg::dp_ctrl_t ctrl;
  logic              out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_frames_q  <= sfd_pkg::RST_DELAY_FRAMES;
      feedback_gain_q <= sfd_pkg::RST_FEEDBACK_GAIN;
      damp_coef_q     <= sfd_pkg::RST_DAMP_COEF;
      wet_gain_q      <= sfd_pkg::RST_WET_GAIN;
      dry_gain_q      <= sfd_pkg::RST_DRY_GAIN;
      ping_pong_q     <= sfd_pkg::RST_PING_PONG;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfd_pkg::CFG_DELAY_FRAMES:  delay_frames_q  <= cfg_data_i;
        sfd_pkg::CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[14:0];
        sfd_pkg::CFG_DAMP_COEF:     damp_coef_q     <= cfg_data_i;
        sfd_pkg::CFG_WET_GAIN:      wet_gain_q      <= cfg_data_i;
        sfd_pkg::CFG_DRY_GAIN:      dry_gain_q      <= cfg_data_i;
        sfd_pkg::CFG_PING_PONG:     ping_pong_q     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Registers hold what was written; limits apply on the way to the datapath.
  always_comb begin
    cfg.delay_frames  = delay_frames_q;
    cfg.feedback_gain = (feedback_gain_q > sfd_pkg::FEEDBACK_MAX) ?
                        sfd_pkg::FEEDBACK_MAX : feedback_gain_q;
    if (damp_coef_q < sfd_pkg::DAMP_MIN) begin
      cfg.damp_coef = sfd_pkg::DAMP_MIN;
    end else if (damp_coef_q > sfd_pkg::UNITY_GAIN) begin
      cfg.damp_coef = sfd_pkg::UNITY_GAIN;
    end else begin
      cfg.damp_coef = damp_coef_q;
    end
    cfg.wet_gain  = (wet_gain_q > sfd_pkg::UNITY_GAIN) ? sfd_pkg::UNITY_GAIN : wet_gain_q;
    cfg.dry_gain  = (dry_gain_q > sfd_pkg::UNITY_GAIN) ? sfd_pkg::UNITY_GAIN : dry_gain_q;
    cfg.ping_pong = ping_pong_q;
  end

  sfd_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  sfd_datapath #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .left_in_i   (in_i.left_in),
    .right_in_i  (in_i.right_in),
    .left_out_o  (out_o.left_out),
    .right_out_o (out_o.right_out)
  );

  assign out_o.valid = out_valid;

endmodule

`default_nettype wire
